// ===== rtl/sse_pkg.sv =====
`default_nettype none

package sse_pkg;

  // Stream characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Record kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_ID   = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  typedef enum logic [1:0] {
    PH_NAME   = 2'd0,
    PH_VSTART = 2'd1,
    PH_VBODY  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    FLD_NONE  = 2'd0,
    FLD_DATA  = 2'd1,
    FLD_EVENT = 2'd2,
    FLD_ID    = 2'd3
  } field_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_CR,
    OP_BYTE,
    OP_LF,
    OP_NAME_RD,
    OP_NAME_EMIT,
    OP_ID_RD,
    OP_ID_EMIT,
    OP_END,
    OP_FIN
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CR,
    S_BYTE,
    S_LF,
    S_NAME_RD,
    S_NAME_EM,
    S_ID_RD,
    S_ID_EM,
    S_END,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_is_cr;
    logic in_is_lf;
    logic held_cr;
    logic after_lf;
    logic byte_is_cr;
    logic name_empty;
    logic id_empty;
    logic name_last;
    logic id_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/sse_ctrl.sv =====
`default_nettype none

module sse_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sse_pkg::status_t sts_i,
  output sse_pkg::cmd_t         cmd_o
);

  sse_pkg::state_e state_q, state_d;

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sse_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through the steps of one word
  always_comb begin
    state_d = state_q;
    case (state_q)
      sse_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_is_cr) begin
            state_d = sts_i.held_cr ? sse_pkg::S_CR : sse_pkg::S_IDLE;
          end else if (sts_i.in_is_lf) begin
            if (!sts_i.after_lf) begin
              state_d = sse_pkg::S_LF;
            end else if (!sts_i.name_empty) begin
              state_d = sse_pkg::S_NAME_RD;
            end else if (!sts_i.id_empty) begin
              state_d = sse_pkg::S_ID_RD;
            end else begin
              state_d = sse_pkg::S_END;
            end
          end else begin
            state_d = sts_i.held_cr ? sse_pkg::S_CR : sse_pkg::S_BYTE;
          end
        end
      end
      sse_pkg::S_CR: begin
        if (sts_i.out_free) begin
          state_d = sts_i.byte_is_cr ? sse_pkg::S_FIN : sse_pkg::S_BYTE;
        end
      end
      sse_pkg::S_BYTE, sse_pkg::S_LF, sse_pkg::S_END: begin
        if (sts_i.out_free) begin
          state_d = sse_pkg::S_FIN;
        end
      end
      sse_pkg::S_NAME_RD: state_d = sse_pkg::S_NAME_EM;
      sse_pkg::S_NAME_EM: begin
        if (sts_i.out_free) begin
          if (!sts_i.name_last) begin
            state_d = sse_pkg::S_NAME_RD;
          end else if (!sts_i.id_empty) begin
            state_d = sse_pkg::S_ID_RD;
          end else begin
            state_d = sse_pkg::S_END;
          end
        end
      end
      sse_pkg::S_ID_RD: state_d = sse_pkg::S_ID_EM;
      sse_pkg::S_ID_EM: begin
        if (sts_i.out_free) begin
          state_d = sts_i.id_last ? sse_pkg::S_END : sse_pkg::S_ID_RD;
        end
      end
      sse_pkg::S_FIN: begin
        if (sts_i.out_free) begin
          state_d = sse_pkg::S_IDLE;
        end
      end
      default: state_d = sse_pkg::S_IDLE;
    endcase
  end

  // Issue one datapath operation per cycle; output steps hold a no-op while the output is not free
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = sse_pkg::OP_NOP;
    case (state_q)
      sse_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = sse_pkg::OP_ACCEPT;
        end
      end
      sse_pkg::S_CR:      if (sts_i.out_free) cmd_o.op = sse_pkg::OP_CR;
      sse_pkg::S_BYTE:    if (sts_i.out_free) cmd_o.op = sse_pkg::OP_BYTE;
      sse_pkg::S_LF:      if (sts_i.out_free) cmd_o.op = sse_pkg::OP_LF;
      sse_pkg::S_NAME_RD: cmd_o.op = sse_pkg::OP_NAME_RD;
      sse_pkg::S_NAME_EM: if (sts_i.out_free) cmd_o.op = sse_pkg::OP_NAME_EMIT;
      sse_pkg::S_ID_RD:   cmd_o.op = sse_pkg::OP_ID_RD;
      sse_pkg::S_ID_EM:   if (sts_i.out_free) cmd_o.op = sse_pkg::OP_ID_EMIT;
      sse_pkg::S_END:     if (sts_i.out_free) cmd_o.op = sse_pkg::OP_END;
      sse_pkg::S_FIN:     if (sts_i.out_free) cmd_o.op = sse_pkg::OP_FIN;
      default:            cmd_o.op = sse_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sse_datapath.sv =====
`default_nettype none

module sse_datapath #(
  parameter int MAX_FIELD_LEN = 31
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     rx_byte_i,
  input  wire sse_pkg::cmd_t  cmd_i,
  output sse_pkg::status_t    sts_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          record_kind_o,
  output logic [7:0]          record_byte_o,
  output logic                run_last_o,
  output logic                id_present_o,
  output logic                field_truncated_o
);

  localparam int LW = $clog2(MAX_FIELD_LEN + 1);
  localparam int AW = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_FIELD_LEN);

  // Per-position name letter hits: {id, data, event}
  function automatic logic [2:0] name_hits(input logic [2:0] pos, input logic [7:0] ch);
    logic [2:0] hits;
    hits = 3'b000;
    case (pos)
      3'd0: hits = {ch == 8'h69, ch == 8'h64, ch == 8'h65};
      3'd1: hits = {ch == 8'h64, ch == 8'h61, ch == 8'h76};
      3'd2: hits = {1'b0, ch == 8'h74, ch == 8'h65};
      3'd3: hits = {1'b0, ch == 8'h61, ch == 8'h6E};
      3'd4: hits = {1'b0, 1'b0, ch == 8'h74};
      default: hits = 3'b000;
    endcase
    return hits;
  endfunction

  // Parser state
  sse_pkg::phase_e phase_q, phase_d;
  sse_pkg::field_e field_q, field_d;
  logic [2:0]    prog_q, prog_d;
  logic [2:0]    cand_q, cand_d;
  logic          held_q, held_d;
  logic          after_q, after_d;
  logic          started_q, started_d;
  logic [LW-1:0] name_len_q, name_len_d;
  logic [LW-1:0] id_len_q, id_len_d;
  logic          id_seen_q, id_seen_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [7:0]    byte_q, byte_d;

  // Stores and their read registers
  logic [7:0] name_mem [MAX_FIELD_LEN];
  logic [7:0] id_mem [MAX_FIELD_LEN];
  logic [7:0] name_rd_q;
  logic [7:0] id_rd_q;

  // Pending record and output register
  logic       pend_v_q, pend_v_d;
  logic [1:0] pend_kind_q;
  logic [7:0] pend_byte_q;
  logic       pend_idp_q, pend_trunc_q;
  logic       out_v_q, out_v_d;
  logic [1:0] out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_last_q, out_idp_q, out_trunc_q;

  logic            out_free;
  logic [7:0]      ord_byte;
  logic            do_recog, do_value, do_line_reset, fin;
  logic            name_we, id_we;
  logic            emit_v;
  logic [1:0]      emit_kind;
  logic [7:0]      emit_byte;
  logic            emit_idp, emit_trunc;
  sse_pkg::field_e rec_field;
  logic            move;

  assign out_free = !out_v_q || out_ready_i;
  assign ord_byte = (cmd_i.op == sse_pkg::OP_CR) ? sse_pkg::CH_CR : byte_q;

  // Report status to the controller
  always_comb begin
    sts_o.in_is_cr   = (rx_byte_i == sse_pkg::CH_CR);
    sts_o.in_is_lf   = (rx_byte_i == sse_pkg::CH_LF);
    sts_o.held_cr    = held_q;
    sts_o.after_lf   = after_q;
    sts_o.byte_is_cr = (byte_q == sse_pkg::CH_CR);
    sts_o.name_empty = (name_len_q == '0);
    sts_o.id_empty   = (id_len_q == '0);
    sts_o.name_last  = (idx_q == name_len_q - LW'(1));
    sts_o.id_last    = (idx_q == id_len_q - LW'(1));
    sts_o.out_free   = out_free;
  end

  // Decode the field named so far
  always_comb begin
    if (cand_q[0] && prog_q == 3'd5) begin
      rec_field = sse_pkg::FLD_EVENT;
    end else if (cand_q[1] && prog_q == 3'd4) begin
      rec_field = sse_pkg::FLD_DATA;
    end else if (cand_q[2] && prog_q == 3'd2) begin
      rec_field = sse_pkg::FLD_ID;
    end else begin
      rec_field = sse_pkg::FLD_NONE;
    end
  end

  // Carry out the current operation
  always_comb begin
    phase_d    = phase_q;
    field_d    = field_q;
    prog_d     = prog_q;
    cand_d     = cand_q;
    held_d     = held_q;
    after_d    = after_q;
    started_d  = started_q;
    name_len_d = name_len_q;
    id_len_d   = id_len_q;
    id_seen_d  = id_seen_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    byte_d     = byte_q;
    do_recog      = 1'b0;
    do_value      = 1'b0;
    do_line_reset = 1'b0;
    fin           = 1'b0;
    name_we       = 1'b0;
    id_we         = 1'b0;
    emit_v        = 1'b0;
    emit_kind     = sse_pkg::KIND_DATA;
    emit_byte     = 8'h00;
    emit_idp      = 1'b0;
    emit_trunc    = 1'b0;

    case (cmd_i.op)
      sse_pkg::OP_ACCEPT: begin
        byte_d = rx_byte_i;
        held_d = (rx_byte_i == sse_pkg::CH_CR);
      end
      sse_pkg::OP_CR, sse_pkg::OP_BYTE: begin
        after_d = 1'b0;
        case (phase_q)
          sse_pkg::PH_NAME: begin
            if (ord_byte == sse_pkg::CH_COLON) begin
              do_recog = 1'b1;
              phase_d  = sse_pkg::PH_VSTART;
            end else begin
              cand_d = cand_q & name_hits(prog_q, ord_byte);
              if (prog_q != 3'd7) begin
                prog_d = prog_q + 3'd1;
              end
            end
          end
          sse_pkg::PH_VSTART: begin
            phase_d  = sse_pkg::PH_VBODY;
            do_value = (ord_byte != sse_pkg::CH_SPACE);
          end
          default: do_value = 1'b1;
        endcase
      end
      sse_pkg::OP_LF: begin
        do_recog      = (phase_q == sse_pkg::PH_NAME);
        do_line_reset = 1'b1;
        after_d       = 1'b1;
      end
      sse_pkg::OP_NAME_EMIT: begin
        emit_v    = 1'b1;
        emit_kind = sse_pkg::KIND_NAME;
        emit_byte = name_rd_q;
        idx_d     = sts_o.name_last ? '0 : idx_q + LW'(1);
      end
      sse_pkg::OP_ID_EMIT: begin
        emit_v    = 1'b1;
        emit_kind = sse_pkg::KIND_ID;
        emit_byte = id_rd_q;
        idx_d     = sts_o.id_last ? '0 : idx_q + LW'(1);
      end
      sse_pkg::OP_END: begin
        emit_v        = 1'b1;
        emit_kind     = sse_pkg::KIND_END;
        emit_idp      = id_seen_q;
        emit_trunc    = ovf_q;
        name_len_d    = '0;
        id_len_d      = '0;
        id_seen_d     = 1'b0;
        ovf_d         = 1'b0;
        started_d     = 1'b0;
        after_d       = 1'b0;
        do_line_reset = 1'b1;
      end
      sse_pkg::OP_FIN: fin = 1'b1;
      default: ;
    endcase

    // Recognise the line's field at colon or line end
    if (do_recog) begin
      field_d = rec_field;
      case (rec_field)
        sse_pkg::FLD_EVENT: name_len_d = '0;
        sse_pkg::FLD_DATA: begin
          if (started_q) begin
            emit_v    = 1'b1;
            emit_kind = sse_pkg::KIND_DATA;
            emit_byte = sse_pkg::CH_LF;
          end
          started_d = 1'b1;
        end
        sse_pkg::FLD_ID: begin
          id_len_d  = '0;
          id_seen_d = 1'b1;
        end
        default: ;
      endcase
    end

    // Route a value byte: stream data, store name and id, drop excess
    if (do_value) begin
      case (field_q)
        sse_pkg::FLD_DATA: begin
          emit_v    = 1'b1;
          emit_kind = sse_pkg::KIND_DATA;
          emit_byte = ord_byte;
        end
        sse_pkg::FLD_EVENT: begin
          if (name_len_q < MaxLen) begin
            name_we    = 1'b1;
            name_len_d = name_len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        sse_pkg::FLD_ID: begin
          if (id_len_q < MaxLen) begin
            id_we    = 1'b1;
            id_len_d = id_len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Start a fresh line
    if (do_line_reset) begin
      phase_d = sse_pkg::PH_NAME;
      prog_d  = 3'd0;
      cand_d  = 3'b111;
      field_d = sse_pkg::FLD_NONE;
    end
  end

  // Shift records through the pending slot so the last one is known
  assign move = pend_v_q && (emit_v || fin);

  always_comb begin
    pend_v_d = pend_v_q;
    if (emit_v) begin
      pend_v_d = 1'b1;
    end else if (fin) begin
      pend_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (move) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sse_pkg::PH_NAME;
      field_q    <= sse_pkg::FLD_NONE;
      prog_q     <= 3'd0;
      cand_q     <= 3'b111;
      held_q     <= 1'b0;
      after_q    <= 1'b0;
      started_q  <= 1'b0;
      name_len_q <= '0;
      id_len_q   <= '0;
      id_seen_q  <= 1'b0;
      ovf_q      <= 1'b0;
      idx_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      field_q    <= field_d;
      prog_q     <= prog_d;
      cand_q     <= cand_d;
      held_q     <= held_d;
      after_q    <= after_d;
      started_q  <= started_d;
      name_len_q <= name_len_d;
      id_len_q   <= id_len_d;
      id_seen_q  <= id_seen_d;
      ovf_q      <= ovf_d;
      idx_q      <= idx_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (emit_v) begin
      pend_kind_q  <= emit_kind;
      pend_byte_q  <= emit_byte;
      pend_idp_q   <= emit_idp;
      pend_trunc_q <= emit_trunc;
    end
    if (move) begin
      out_kind_q  <= pend_kind_q;
      out_byte_q  <= pend_byte_q;
      out_last_q  <= fin;
      out_idp_q   <= pend_idp_q;
      out_trunc_q <= pend_trunc_q;
    end
  end

  // Event-name store
  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[name_len_q[AW-1:0]] <= ord_byte;
    end
    if (cmd_i.op == sse_pkg::OP_NAME_RD) begin
      name_rd_q <= name_mem[idx_q[AW-1:0]];
    end
  end

  // Id store
  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[id_len_q[AW-1:0]] <= ord_byte;
    end
    if (cmd_i.op == sse_pkg::OP_ID_RD) begin
      id_rd_q <= id_mem[idx_q[AW-1:0]];
    end
  end

  assign out_valid_o       = out_v_q;
  assign record_kind_o     = out_kind_q;
  assign record_byte_o     = out_byte_q;
  assign run_last_o        = out_last_q;
  assign id_present_o      = out_idp_q;
  assign field_truncated_o = out_trunc_q;

endmodule

`default_nettype wire

// ===== rtl/sse_event_parser_top.sv =====
// Flow: an ordinary byte reaches the output register through the accept, parse and finish
// steps, a held CR replayed before parse; a lone CR finishes in its accept cycle.
// A new byte is taken only once the last byte is finished, and each output step waits while
// the output register is full and not taken; an event end adds a store read, then an emit,
// for each stored event-name and id byte, then the end record before the finish step.
// Reset: rst_ni asynchronous, active low, clears parser state and the pending and output valid bits.
`default_nettype none

module sse_event_parser_top #(
  parameter int MAX_FIELD_LEN = 31
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      record_kind_o,
  output logic [7:0]      record_byte_o,
  output logic            run_last_o,
  output logic            id_present_o,
  output logic            field_truncated_o
);

  sse_pkg::cmd_t    cmd;
  sse_pkg::status_t sts;

  // Sequence each word
  sse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Parse, store and emit
  sse_datapath #(
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_byte_i         (rx_byte_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .record_kind_o     (record_kind_o),
    .record_byte_o     (record_byte_o),
    .run_last_o        (run_last_o),
    .id_present_o      (id_present_o),
    .field_truncated_o (field_truncated_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sse_checker.sv =====
`default_nettype none

module sse_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [7:0] rx_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] record_kind_o,
  input wire logic [7:0] record_byte_o,
  input wire logic       run_last_o,
  input wire logic       id_present_o,
  input wire logic       field_truncated_o
);

  // A waiting input word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("waiting input word changed");

  // A stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(record_kind_o)
      && $stable(record_byte_o) && $stable(run_last_o))
    else $error("stalled output word changed");

  // End of event always closes the run of its byte and carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == sse_pkg::KIND_END |-> run_last_o && record_byte_o == 8'h00)
    else $error("end record malformed");

  // Flags appear only on end records
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o != sse_pkg::KIND_END |-> !id_present_o && !field_truncated_o)
    else $error("flags set on a byte record");

  // More words of the same byte still to come: no new byte taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> !in_ready_o)
    else $error("input taken while a run is unfinished");

endmodule

bind sse_event_parser_top sse_checker u_sse_checker (.*);

`default_nettype wire
